### rtl/mcmsg_pkg.sv
`default_nettype none

package mcmsg_pkg;

	// realtime bytes
	localparam logic [7:0] MB_CLOCK    = 8'hf8;
	localparam logic [7:0] MB_START    = 8'hfa;
	localparam logic [7:0] MB_CONTINUE = 8'hfb;
	localparam logic [7:0] MB_STOP     = 8'hfc;

	// item kinds
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_BYTE = 1'b1;

	// clock_mode codes, any other code acts as auto
	localparam logic [1:0] MODE_MASTER = 2'd0;
	localparam logic [1:0] MODE_SLAVE  = 2'd1;
	localparam logic [1:0] MODE_AUTO   = 2'd2;

	// register indexes
	localparam logic CFG_CLOCK_MODE = 1'b0;
	localparam logic CFG_BPM_PERIOD = 1'b1;

	localparam int unsigned PERIOD_W = 30;

	localparam logic [1:0]          MODE_RESET   = MODE_AUTO;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 30'd5208333;

	localparam logic [15:0] GAP_IDLE        = 16'hffff;
	localparam logic [15:0] GAP_SLAVE_LIMIT = 16'h0fff;
	localparam logic [31:0] PHASE_STEP      = 32'd1000000;
	localparam logic [7:0]  PEND_MAX        = 8'hff;
	localparam logic [1:0]  INTERP_DONE     = 2'd3;
	localparam logic [2:0]  SIX_LAST        = 3'd5;

endpackage

`default_nettype wire

### rtl/midi_clock_master_slave_generator.sv
// result: each accepted input beat is registered and comes out as its result beat in the next cycle
// throughput: one item per cycle; the result register frees itself as it is taken,
// so a new item goes in every cycle while the output side keeps up
// reset: arst_n resets all tempo, gap and interpolation state at once (gap to idle) and loads
// clock_mode = auto and bpm_period = 5208333; no clearing pass is needed
`default_nettype none

module midi_clock_master_slave_generator (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// item channel
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             req_type,
	input  wire logic [7:0]                       midi_byte,
	// result channel
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  clock_pulse,
	output logic                                  start_pulse,
	output logic                                  stop_pulse,
	output logic                                  slave_active,
	output logic [2:0]                            sub_count,
	output logic [1:0]                            beat_count,
	// register write channel
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic                             cfg_index,
	input  wire logic [mcmsg_pkg::PERIOD_W-1:0]   cfg_data
);

	// configuration registers
	logic [1:0]                         clock_mode_q;
	logic [mcmsg_pkg::PERIOD_W-1:0]     bpm_period_q;

	// tempo state
	logic [15:0] gap_q;           // ticks since last clock byte, saturates at idle
	logic [15:0] meas_q;          // gap latched at the latest clock byte
	logic [15:0] delay_q;         // ticks to the next interpolated clock
	logic [1:0]  sent_q;          // interpolated clocks issued since last clock byte
	logic [7:0]  pend_q;          // queued clock requests
	logic [31:0] phase_q;         // master tempo accumulator
	logic        slave_q;
	logic        startp_q;
	logic        stopp_q;
	logic [2:0]  six_q;
	logic [1:0]  four_q;

	// next state
	logic [15:0] gap_n, meas_n, delay_n;
	logic [1:0]  sent_n;
	logic [7:0]  pend_n;
	logic [31:0] phase_n;
	logic        slave_n, startp_n, stopp_n;
	logic [2:0]  six_n;
	logic [1:0]  four_n;
	logic        clk_c, start_c, stop_c;

	// master accumulator: add the step, then test against the period by one subtract
	logic [31:0] phase_sum;
	logic [32:0] phase_diff;
	logic        phase_fire;

	// clock byte queues the requests not yet covered by interpolation
	logic [2:0] clk_add;
	logic [8:0] pend_sum;

	logic in_fire;

	// the result register can take a new beat when empty or being emptied
	assign in_ready  = !out_valid || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign phase_sum  = phase_q + mcmsg_pkg::PHASE_STEP;
	assign phase_diff = {1'b0, phase_sum} - {3'b000, bpm_period_q};
	assign phase_fire = !phase_diff[32] && (phase_diff != 33'd0);

	assign clk_add  = 3'd4 - {1'b0, sent_q};
	assign pend_sum = {1'b0, pend_q} + {6'b000000, clk_add};

	always_comb begin
		gap_n    = gap_q;
		meas_n   = meas_q;
		delay_n  = delay_q;
		sent_n   = sent_q;
		pend_n   = pend_q;
		phase_n  = phase_q;
		slave_n  = slave_q;
		startp_n = startp_q;
		stopp_n  = stopp_q;
		six_n    = six_q;
		four_n   = four_q;
		clk_c    = 1'b0;
		start_c  = 1'b0;
		stop_c   = 1'b0;

		if (req_type == mcmsg_pkg::REQ_BYTE) begin
			case (midi_byte)
				mcmsg_pkg::MB_CLOCK: begin
					// latch the gap, restart timing, spread interpolated clocks over it a quarter gap apart
					meas_n  = gap_q;
					gap_n   = 16'd0;
					pend_n  = pend_sum[8] ? mcmsg_pkg::PEND_MAX : pend_sum[7:0];
					sent_n  = 2'd0;
					delay_n = {2'b00, gap_q[15:2]};
				end
				mcmsg_pkg::MB_START: begin
					startp_n = 1'b1;
					if (gap_q > mcmsg_pkg::GAP_SLAVE_LIMIT) begin
						gap_n = 16'd0;
					end
					pend_n = 8'd0;
					sent_n = mcmsg_pkg::INTERP_DONE;
				end
				mcmsg_pkg::MB_STOP: begin
					stopp_n = 1'b1;
				end
				default: begin
					// continue and all other bytes are ignored
				end
			endcase
		end else begin
			if (gap_q != mcmsg_pkg::GAP_IDLE) begin
				gap_n = gap_q + 16'd1;
			end

			case (clock_mode_q)
				mcmsg_pkg::MODE_MASTER: slave_n = 1'b0;
				mcmsg_pkg::MODE_SLAVE:  slave_n = 1'b1;
				default:                slave_n = (gap_n < mcmsg_pkg::GAP_SLAVE_LIMIT);
			endcase

			// interpolated clock once the quarter gap has run out
			delay_n = delay_q - 16'd1;
			if (delay_n == 16'd0 && sent_q != mcmsg_pkg::INTERP_DONE) begin
				sent_n = sent_q + 2'd1;
				if (pend_q != mcmsg_pkg::PEND_MAX) begin
					pend_n = pend_q + 8'd1;
				end
				delay_n = {2'b00, meas_q[15:2]};
			end

			if (startp_q) begin
				startp_n = 1'b0;
				start_c  = 1'b1;
				six_n    = 3'd0;
				four_n   = 2'd0;
			end
			if (stopp_q) begin
				stopp_n = 1'b0;
				stop_c  = 1'b1;
			end

			// a queued request is spent even in master mode, but only sounds as slave
			if (pend_n != 8'd0) begin
				pend_n = pend_n - 8'd1;
				clk_c  = slave_n;
			end else if (!slave_n) begin
				if (phase_fire) begin
					phase_n = phase_diff[31:0];
					clk_c   = 1'b1;
				end else begin
					phase_n = phase_sum;
				end
			end

			if (clk_c) begin
				if (six_n == mcmsg_pkg::SIX_LAST) begin
					six_n  = 3'd0;
					four_n = four_n + 2'd1;
				end else begin
					six_n = six_n + 3'd1;
				end
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_mode_q <= mcmsg_pkg::MODE_RESET;
			bpm_period_q <= mcmsg_pkg::PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mcmsg_pkg::CFG_CLOCK_MODE: clock_mode_q <= cfg_data[1:0];
				mcmsg_pkg::CFG_BPM_PERIOD: bpm_period_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// state update on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q    <= mcmsg_pkg::GAP_IDLE;
			meas_q   <= 16'd0;
			delay_q  <= 16'd0;
			sent_q   <= mcmsg_pkg::INTERP_DONE;
			pend_q   <= 8'd0;
			phase_q  <= 32'd0;
			slave_q  <= 1'b0;
			startp_q <= 1'b0;
			stopp_q  <= 1'b0;
			six_q    <= 3'd0;
			four_q   <= 2'd0;
		end else if (in_fire) begin
			gap_q    <= gap_n;
			meas_q   <= meas_n;
			delay_q  <= delay_n;
			sent_q   <= sent_n;
			pend_q   <= pend_n;
			phase_q  <= phase_n;
			slave_q  <= slave_n;
			startp_q <= startp_n;
			stopp_q  <= stopp_n;
			six_q    <= six_n;
			four_q   <= four_n;
		end
	end

	// result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_fire) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// result register: payload, held while stalled
	always_ff @(posedge clk) begin
		if (in_fire) begin
			clock_pulse  <= clk_c;
			start_pulse  <= start_c;
			stop_pulse   <= stop_c;
			slave_active <= slave_n;
			sub_count    <= six_n;
			beat_count   <= four_n;
		end
	end

endmodule

`default_nettype wire

### rtl/mcmsg_checker.sv
`default_nettype none

module mcmsg_props (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       clock_pulse,
	input wire logic       start_pulse,
	input wire logic       stop_pulse,
	input wire logic       slave_active,
	input wire logic [2:0] sub_count,
	input wire logic [1:0] beat_count
);

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(clock_pulse) &&
		$stable(start_pulse) && $stable(stop_pulse) && $stable(slave_active) &&
		$stable(sub_count) && $stable(beat_count))
	else $error("stalled result beat changed");

	// every accepted item yields a result beat in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
	else $error("accepted item gave no result beat");

	// an empty result register never blocks the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
	else $error("input stalled with empty result register");

	// start clears both dividers, a clock on the same tick may advance the first
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && start_pulse |-> beat_count == 2'd0 &&
		((sub_count == 3'd0 && !clock_pulse) || (sub_count == 3'd1 && clock_pulse)))
	else $error("start did not clear the dividers");

	// divide-by-six count stays in range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sub_count <= mcmsg_pkg::SIX_LAST)
	else $error("sub_count out of range");

endmodule

bind midi_clock_master_slave_generator mcmsg_props u_mcmsg_props (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.clock_pulse  (clock_pulse),
	.start_pulse  (start_pulse),
	.stop_pulse   (stop_pulse),
	.slave_active (slave_active),
	.sub_count    (sub_count),
	.beat_count   (beat_count)
);

`default_nettype wire

### tb/mcmsg_checker.sv
`default_nettype none

module mcmsg_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic                           in_ready,
	input  wire logic                           req_type,
	input  wire logic [7:0]                     midi_byte,
	input  wire logic                           out_valid,
	input  wire logic                           out_ready,
	input  wire logic                           clock_pulse,
	input  wire logic                           start_pulse,
	input  wire logic                           stop_pulse,
	input  wire logic                           slave_active,
	input  wire logic [2:0]                     sub_count,
	input  wire logic [1:0]                     beat_count,
	input  wire logic                           cfg_valid,
	input  wire logic                           cfg_ready,
	input  wire logic                           cfg_index,
	input  wire logic [mcmsg_pkg::PERIOD_W-1:0] cfg_data,
	output int unsigned                         mismatches,
	output int unsigned                         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic       clock_pulse;
		logic       start_pulse;
		logic       stop_pulse;
		logic       slave_active;
		logic [2:0] sub_count;
		logic [1:0] beat_count;
	} sync_beat_t;

	// registers as the block should hold them
	logic [1:0]                     mode_reg;
	logic [mcmsg_pkg::PERIOD_W-1:0] period_reg;

	// tempo and sync state
	logic [15:0] gap_ticks;
	logic [15:0] last_gap;
	logic [15:0] interp_wait;
	logic [1:0]  interp_issued;
	logic [7:0]  queued_clocks;
	logic [31:0] tempo_acc;
	logic        following_ext;
	logic        start_due;
	logic        stop_due;
	logic [2:0]  six_pos;
	logic [1:0]  four_pos;

	sync_beat_t due_beats[$];

	// add clock requests, held at the top of the range
	function automatic void queue_clocks(input logic [2:0] n);
		logic [8:0] sum;
		sum = {1'b0, queued_clocks} + {6'd0, n};
		queued_clocks = (sum > {1'b0, mcmsg_pkg::PEND_MAX}) ? mcmsg_pkg::PEND_MAX : sum[7:0];
	endfunction

	function automatic sync_beat_t sync_step(input logic kind, input logic [7:0] rt_byte);
		sync_beat_t r;
		r = '0;
		if (kind == mcmsg_pkg::REQ_BYTE) begin
			case (rt_byte)
				mcmsg_pkg::MB_CLOCK: begin
					last_gap = gap_ticks;
					gap_ticks = '0;
					queue_clocks(3'd4 - {1'b0, interp_issued});
					interp_issued = '0;
					interp_wait = {2'b00, last_gap[15:2]};
				end
				mcmsg_pkg::MB_START: begin
					start_due = 1'b1;
					if (gap_ticks > mcmsg_pkg::GAP_SLAVE_LIMIT)
						gap_ticks = '0;
					queued_clocks = '0;
					interp_issued = mcmsg_pkg::INTERP_DONE;
				end
				mcmsg_pkg::MB_STOP: stop_due = 1'b1;
				// continue and every other byte are ignored
				default: ;
			endcase
		end else begin
			if (gap_ticks != mcmsg_pkg::GAP_IDLE)
				gap_ticks = gap_ticks + 16'd1;
			case (mode_reg)
				mcmsg_pkg::MODE_MASTER: following_ext = 1'b0;
				mcmsg_pkg::MODE_SLAVE:  following_ext = 1'b1;
				default: following_ext = (gap_ticks < mcmsg_pkg::GAP_SLAVE_LIMIT);
			endcase
			interp_wait = interp_wait - 16'd1;
			if (interp_wait == 16'd0 && interp_issued != mcmsg_pkg::INTERP_DONE) begin
				interp_issued = interp_issued + 2'd1;
				queue_clocks(3'd1);
				interp_wait = {2'b00, last_gap[15:2]};
			end
			if (start_due) begin
				start_due = 1'b0;
				r.start_pulse = 1'b1;
				six_pos = '0;
				four_pos = '0;
			end
			if (stop_due) begin
				stop_due = 1'b0;
				r.stop_pulse = 1'b1;
			end
			if (queued_clocks != 8'd0) begin
				queued_clocks = queued_clocks - 8'd1;
				r.clock_pulse = following_ext;
			end else if (!following_ext) begin
				tempo_acc = tempo_acc + mcmsg_pkg::PHASE_STEP;
				if (tempo_acc > {2'b00, period_reg}) begin
					tempo_acc = tempo_acc - {2'b00, period_reg};
					r.clock_pulse = 1'b1;
				end
			end
			if (r.clock_pulse) begin
				if (six_pos == mcmsg_pkg::SIX_LAST) begin
					six_pos = '0;
					four_pos = four_pos + 2'd1;
				end else begin
					six_pos = six_pos + 3'd1;
				end
			end
		end
		r.slave_active = following_ext;
		r.sub_count = six_pos;
		r.beat_count = four_pos;
		return r;
	endfunction

	function automatic void check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sync_beat_t want;
		if (!arst_n) begin
			mode_reg = mcmsg_pkg::MODE_RESET;
			period_reg = mcmsg_pkg::PERIOD_RESET;
			gap_ticks = mcmsg_pkg::GAP_IDLE;
			last_gap = '0;
			interp_wait = '0;
			interp_issued = mcmsg_pkg::INTERP_DONE;
			queued_clocks = '0;
			tempo_acc = '0;
			following_ext = 1'b0;
			start_due = 1'b0;
			stop_due = 1'b0;
			six_pos = '0;
			four_pos = '0;
			due_beats.delete();
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == mcmsg_pkg::CFG_CLOCK_MODE)
					mode_reg = cfg_data[1:0];
				else
					period_reg = cfg_data;
			end
			// result first, so a beat taken this edge never meets its own prediction
			if (out_valid && out_ready) begin
				if (due_beats.size() == 0) begin
					$error("result beat with nothing expected");
					mismatches++;
				end else begin
					want = due_beats.pop_front();
					check_field("clock_pulse", want.clock_pulse, clock_pulse);
					check_field("start_pulse", want.start_pulse, start_pulse);
					check_field("stop_pulse", want.stop_pulse, stop_pulse);
					check_field("slave_active", want.slave_active, slave_active);
					check_field("sub_count", want.sub_count, sub_count);
					check_field("beat_count", want.beat_count, beat_count);
				end
			end
			if (in_valid && in_ready)
				due_beats.push_back(sync_step(req_type, midi_byte));
		end
		pending = due_beats.size();
	end

endmodule

`default_nettype wire

### tb/tb_top.sv
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// clock_mode code with no name of its own, acts as auto
	localparam logic [1:0]                     MODE_SPARE = 2'd3;
	localparam logic [mcmsg_pkg::PERIOD_W-1:0] PERIOD_MAX = 30'd625000000;
	localparam int unsigned                    NUM_PHASES = 8;
	localparam int unsigned                    PHASE_ITEMS = 70;
	// far beyond the longest quiet stretch of a correct run (the long result hold-off)
	localparam int unsigned                    STALL_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic                           req_type = mcmsg_pkg::REQ_TICK;
	logic [7:0]                     midi_byte = 8'h00;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic                           clock_pulse;
	logic                           start_pulse;
	logic                           stop_pulse;
	logic                           slave_active;
	logic [2:0]                     sub_count;
	logic [1:0]                     beat_count;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic                           cfg_index = mcmsg_pkg::CFG_CLOCK_MODE;
	logic [mcmsg_pkg::PERIOD_W-1:0] cfg_data = '0;

	int unsigned mismatches;
	int unsigned pending;

	// sender bookkeeping
	int unsigned burst_left = 0;
	int unsigned items_done = 0;
	// asks the result side for its one long hold-off
	logic        squeeze_req = 1'b0;
	int unsigned idle_cycles = 0;

	logic [1:0]                     mode_plan[NUM_PHASES];
	logic [mcmsg_pkg::PERIOD_W-1:0] period_plan[NUM_PHASES];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	midi_clock_master_slave_generator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.midi_byte    (midi_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.clock_pulse  (clock_pulse),
		.start_pulse  (start_pulse),
		.stop_pulse   (stop_pulse),
		.slave_active (slave_active),
		.sub_count    (sub_count),
		.beat_count   (beat_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	mcmsg_checker sync_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.midi_byte    (midi_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.clock_pulse  (clock_pulse),
		.start_pulse  (start_pulse),
		.stop_pulse   (stop_pulse),
		.slave_active (slave_active),
		.sub_count    (sub_count),
		.beat_count   (beat_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	// watchdog: any beat on any channel counts as progress
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side: a stall pattern of its own that rotates through four styles,
	// plus one long hold-off so the block backs up into its input
	initial begin : result_sink
		int unsigned cyc;
		int unsigned hold_left;
		bit          squeezed;
		cyc = 0;
		hold_left = 0;
		squeezed = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (squeeze_req && !squeezed) begin
				squeezed = 1'b1;
				hold_left = 400;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready = 1'b0;
			end else begin
				case ((cyc >> 6) % 4)
					0: out_ready = 1'b1;
					1: out_ready = ($urandom_range(0, 3) != 0);
					2: out_ready = ((cyc % 3) != 0);
					default: out_ready = 1'($urandom_range(0, 1));
				endcase
			end
		end
	end

	// offer one item and wait until it is taken; returns at a falling edge with valid
	// still high, so the caller either offers the next item or drops valid
	task automatic send_item(input logic kind, input logic [7:0] rt_byte);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			// some bursts run straight on with no gap at all
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req_type = kind;
		midi_byte = rt_byte;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		// ignored bytes do not count towards the item budget
		if (kind == mcmsg_pkg::REQ_TICK || rt_byte == mcmsg_pkg::MB_CLOCK
				|| rt_byte == mcmsg_pkg::MB_START || rt_byte == mcmsg_pkg::MB_STOP)
			items_done++;
	endtask

	// sender pauses until every expected result has come back
	task automatic wait_drained();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [mcmsg_pkg::PERIOD_W-1:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// one random stretch of traffic, mostly well-formed clock streams
	task automatic play_random_sequence();
		int unsigned pick;
		int unsigned n;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			// ticks then a clock byte; now and then a long gap for wide interpolation
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
			repeat (n) begin
				if ($urandom_range(0, 39) == 0)
					send_item(mcmsg_pkg::REQ_BYTE,
						$urandom_range(0, 1) ? mcmsg_pkg::MB_START : mcmsg_pkg::MB_STOP);
				// byte field is don't-care on a tick, so let it wander
				send_item(mcmsg_pkg::REQ_TICK, 8'($urandom));
			end
			send_item(mcmsg_pkg::REQ_BYTE, mcmsg_pkg::MB_CLOCK);
		end else if (pick < 70) begin
			send_item(mcmsg_pkg::REQ_BYTE,
				$urandom_range(0, 1) ? mcmsg_pkg::MB_START : mcmsg_pkg::MB_STOP);
			repeat ($urandom_range(1, 6)) send_item(mcmsg_pkg::REQ_TICK, 8'($urandom));
		end else if (pick < 85) begin
			// noise: any byte at all, mostly ignored
			repeat ($urandom_range(1, 4)) send_item(mcmsg_pkg::REQ_BYTE, 8'($urandom));
		end else if (pick == 85) begin
			// clock flood, can drive the request count into saturation
			repeat ($urandom_range(60, 70)) send_item(mcmsg_pkg::REQ_BYTE, mcmsg_pkg::MB_CLOCK);
		end else begin
			repeat ($urandom_range(10, 60)) send_item(mcmsg_pkg::REQ_TICK, 8'($urandom));
		end
	endtask

	initial begin : stimulus
		int unsigned phase_end;
		mode_plan = '{mcmsg_pkg::MODE_AUTO, mcmsg_pkg::MODE_MASTER, mcmsg_pkg::MODE_SLAVE,
			mcmsg_pkg::MODE_MASTER, MODE_SPARE, mcmsg_pkg::MODE_MASTER,
			mcmsg_pkg::MODE_AUTO, mcmsg_pkg::MODE_MASTER};
		period_plan = '{mcmsg_pkg::PERIOD_RESET, 30'd1, PERIOD_MAX, PERIOD_MAX, 30'd0, 30'd0,
			30'($urandom_range(1, PERIOD_MAX)), 30'($urandom_range(1000000, 6000000))};

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed part at reset settings (auto, default period)
		send_item(mcmsg_pkg::REQ_TICK, 8'h00);               // internal tempo, no clock seen yet
		send_item(mcmsg_pkg::REQ_BYTE, mcmsg_pkg::MB_CLOCK); // first clock byte, gap still idle
		repeat (3) send_item(mcmsg_pkg::REQ_TICK, 8'h00);    // now following, queue drains
		send_item(mcmsg_pkg::REQ_BYTE, mcmsg_pkg::MB_CONTINUE); // continue is ignored
		send_item(mcmsg_pkg::REQ_BYTE, 8'h00);               // byte extremes, ignored
		send_item(mcmsg_pkg::REQ_BYTE, 8'hff);
		send_item(mcmsg_pkg::REQ_TICK, mcmsg_pkg::MB_CLOCK); // tick: byte field must not matter
		send_item(mcmsg_pkg::REQ_BYTE, mcmsg_pkg::MB_START);
		send_item(mcmsg_pkg::REQ_TICK, 8'hff);               // start pulse, counters cleared
		send_item(mcmsg_pkg::REQ_BYTE, mcmsg_pkg::MB_STOP);
		send_item(mcmsg_pkg::REQ_TICK, 8'h00);               // stop pulse
		send_item(mcmsg_pkg::REQ_BYTE, mcmsg_pkg::MB_START); // start and stop on the same tick
		send_item(mcmsg_pkg::REQ_BYTE, mcmsg_pkg::MB_STOP);
		send_item(mcmsg_pkg::REQ_TICK, 8'h00);
		send_item(mcmsg_pkg::REQ_BYTE, mcmsg_pkg::MB_CLOCK); // short gap, quick interpolation
		repeat (8) send_item(mcmsg_pkg::REQ_TICK, 8'h00);

		// random part, one register setting per phase
		for (int unsigned p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			// upper data bits are don't-care for the mode register
			write_reg(mcmsg_pkg::CFG_CLOCK_MODE, {28'($urandom), mode_plan[p]});
			write_reg(mcmsg_pkg::CFG_BPM_PERIOD, period_plan[p]);
			if (p == 2)
				squeeze_req = 1'b1;
			phase_end = items_done + PHASE_ITEMS;
			while (items_done < phase_end)
				play_random_sequence();
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
